// ----- design/tared_weight_hex_framer_unit_defines.svh -----
// assertion macros for the framer modules, used by the queue
`ifndef TARED_WEIGHT_HEX_FRAMER_UNIT_DEFINES_SVH
`define TARED_WEIGHT_HEX_FRAMER_UNIT_DEFINES_SVH

// clocked assertion, quiet while reset is held
`define TWHF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// clocked assertion that also holds during reset
`define TWHF_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ----- design/twhf_pkg.sv -----
`timescale 1ns / 1ps

package twhf_pkg;

    // tare and frame sizes
    localparam int TARE_SAMPLES = 15;
    localparam int ADC_W        = 24;
    localparam int TEMP_W       = 16;
    localparam int SUM_W        = 28;
    localparam int CNT_W        = 4;
    localparam int FRAME_LEN    = 19;
    localparam int IDX_W        = $clog2(FRAME_LEN);
    localparam int Q_DEPTH      = 2;

    // reciprocal of the tare count, exact for every sum below 2^SUM_W
    localparam int RECIP_SH = 32;
    localparam int RECIP_W  = 33;
    localparam logic [RECIP_W-1:0] TARE_RECIP =
        RECIP_W'(((64'd1 << RECIP_SH) + 64'(TARE_SAMPLES - 1)) / 64'(TARE_SAMPLES));

    localparam logic [ADC_W-1:0] SIGN_FLIP = 24'h800000;

    // ascii codes
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_ALPHA = 8'h37;

    // one measurement ready for framing
    typedef struct packed {
        logic              neg;
        logic [ADC_W-1:0]  mag;
        logic [7:0]        chk;
        logic [TEMP_W-1:0] temp;
    } frame_rec_t;

    // upper-case hex digit
    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] n8;
        n8 = {4'b0000, nib};
        return (nib < 4'd10) ? (CH_ZERO + n8) : (CH_ALPHA + n8);
    endfunction

endpackage

// ----- design/twhf_front.sv -----
`timescale 1ns / 1ps

module twhf_front (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [39:0]            s_tdata,
    input  logic                   q_ready,
    output logic                   q_push,
    output twhf_pkg::frame_rec_t   q_rec
);

    typedef enum logic [2:0] {
        ST_TARE = 3'b001,
        ST_DIV  = 3'b010,
        ST_RUN  = 3'b100
    } state_t;

    state_t                        state_reg, state_next;
    logic [twhf_pkg::CNT_W-1:0]    count_reg, count_next;
    logic [twhf_pkg::SUM_W-1:0]    sum_reg, sum_next;
    logic [twhf_pkg::ADC_W-1:0]    offset_reg, offset_next;

    logic [twhf_pkg::ADC_W-1:0]    word;
    logic [twhf_pkg::TEMP_W-1:0]   temp;
    logic                          accept;
    logic [twhf_pkg::SUM_W+twhf_pkg::RECIP_W-1:0] prod;
    logic [twhf_pkg::ADC_W:0]      diff;

    assign word = s_tdata[twhf_pkg::ADC_W-1:0] ^ twhf_pkg::SIGN_FLIP;
    assign temp = s_tdata[twhf_pkg::ADC_W +: twhf_pkg::TEMP_W];

    // ready follows the phase
    always_comb begin
        unique case (state_reg)
            ST_TARE: s_tready = 1'b1;
            ST_DIV:  s_tready = 1'b0;
            ST_RUN:  s_tready = q_ready;
            default: s_tready = 1'b0;
        endcase
    end

    assign accept = s_tvalid && s_tready;

    // tare sum divided by the tare count through its reciprocal
    assign prod = {{twhf_pkg::RECIP_W{1'b0}}, sum_reg}
                * {{twhf_pkg::SUM_W{1'b0}}, twhf_pkg::TARE_RECIP};

    // tare, divide, then run
    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        sum_next    = sum_reg;
        offset_next = offset_reg;
        unique case (state_reg)
            ST_TARE: begin
                if (accept) begin
                    sum_next   = sum_reg + {{(twhf_pkg::SUM_W-twhf_pkg::ADC_W){1'b0}}, word};
                    count_next = count_reg + twhf_pkg::CNT_W'(1);
                    if (count_next == twhf_pkg::CNT_W'(twhf_pkg::TARE_SAMPLES))
                        state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                offset_next = prod[twhf_pkg::RECIP_SH +: twhf_pkg::ADC_W];
                state_next  = ST_RUN;
            end
            ST_RUN: begin
            end
            default: state_next = ST_TARE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_TARE;
            count_reg  <= '0;
            sum_reg    <= '0;
            offset_reg <= '0;
        end else begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            sum_reg    <= sum_next;
            offset_reg <= offset_next;
        end
    end

    // classify: sign, magnitude and byte checksum of the difference
    assign diff = {1'b0, word} - {1'b0, offset_reg};

    always_comb begin
        q_rec.neg  = diff[twhf_pkg::ADC_W];
        q_rec.mag  = diff[twhf_pkg::ADC_W] ? (offset_reg - word) : diff[twhf_pkg::ADC_W-1:0];
        // top byte and sign flip cancel for negatives
        q_rec.chk  = diff[7:0] ^ diff[15:8] ^ diff[23:16];
        q_rec.temp = temp;
    end

    assign q_push = accept && (state_reg == ST_RUN);

endmodule

// ----- design/twhf_queue.sv -----
`timescale 1ns / 1ps
`include "tared_weight_hex_framer_unit_defines.svh"

module twhf_queue (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push,
    input  twhf_pkg::frame_rec_t   push_rec,
    output logic                   push_ready,
    input  logic                   pop,
    output logic                   head_valid,
    output twhf_pkg::frame_rec_t   head_rec
);

    localparam int PTR_W = $clog2(twhf_pkg::Q_DEPTH);
    localparam int QC_W  = $clog2(twhf_pkg::Q_DEPTH + 1);

    twhf_pkg::frame_rec_t  mem [twhf_pkg::Q_DEPTH];
    logic [PTR_W-1:0]      wr_ptr_reg, rd_ptr_reg;
    logic [QC_W-1:0]       count_reg, count_next;

    assign push_ready = (count_reg != QC_W'(twhf_pkg::Q_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_rec   = mem[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + QC_W'(1);
        else if (pop && !push)
            count_next = count_reg - QC_W'(1);
    end

    // pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            count_reg <= count_next;
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (push)
            mem[wr_ptr_reg] <= push_rec;
    end

    `TWHF_ASSERT(a_no_push_full, (!push_ready |-> !push), "push into full queue")
    `TWHF_ASSERT(a_no_pop_empty, (!head_valid |-> !pop), "pop from empty queue")
    `TWHF_ASSERT(a_level_track, (##1 (count_reg == $past(count_next))), "queue level mismatch")

endmodule

// ----- design/twhf_back.sv -----
`timescale 1ns / 1ps

module twhf_back (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   head_valid,
    input  twhf_pkg::frame_rec_t   head_rec,
    output logic                   pop,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [7:0]             m_tdata,
    output logic                   m_tlast
);

    logic [twhf_pkg::IDX_W-1:0]   idx_reg, idx_next;
    logic                         valid_reg;
    logic [7:0]                   char_reg, char_next;
    logic                         last_reg, last_next;
    logic                         load;
    logic [7:0]                   tchk;

    assign load = head_valid && (!valid_reg || m_tready);
    assign tchk = head_rec.temp[15:8] ^ head_rec.temp[7:0];

    // pick the character at the current frame position
    always_comb begin
        case (idx_reg)
            5'd0:    char_next = head_rec.neg ? twhf_pkg::CH_ONE : twhf_pkg::CH_ZERO;
            5'd1:    char_next = twhf_pkg::CH_ZERO;
            5'd2:    char_next = twhf_pkg::CH_X;
            5'd3:    char_next = twhf_pkg::CH_ZERO;
            5'd4:    char_next = twhf_pkg::CH_ZERO;
            5'd5:    char_next = twhf_pkg::hex_char(head_rec.mag[23:20]);
            5'd6:    char_next = twhf_pkg::hex_char(head_rec.mag[19:16]);
            5'd7:    char_next = twhf_pkg::hex_char(head_rec.mag[15:12]);
            5'd8:    char_next = twhf_pkg::hex_char(head_rec.mag[11:8]);
            5'd9:    char_next = twhf_pkg::hex_char(head_rec.mag[7:4]);
            5'd10:   char_next = twhf_pkg::hex_char(head_rec.mag[3:0]);
            5'd11:   char_next = twhf_pkg::hex_char(head_rec.chk[7:4]);
            5'd12:   char_next = twhf_pkg::hex_char(head_rec.chk[3:0]);
            5'd13:   char_next = twhf_pkg::hex_char(head_rec.temp[15:12]);
            5'd14:   char_next = twhf_pkg::hex_char(head_rec.temp[11:8]);
            5'd15:   char_next = twhf_pkg::hex_char(head_rec.temp[7:4]);
            5'd16:   char_next = twhf_pkg::hex_char(head_rec.temp[3:0]);
            5'd17:   char_next = twhf_pkg::hex_char(tchk[7:4]);
            default: char_next = twhf_pkg::hex_char(tchk[3:0]);
        endcase
    end

    assign last_next = (idx_reg == twhf_pkg::IDX_W'(twhf_pkg::FRAME_LEN - 1));
    assign pop       = load && last_next;
    assign idx_next  = last_next ? '0 : idx_reg + twhf_pkg::IDX_W'(1);

    // frame position and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            if (load)
                idx_reg <= idx_next;
            if (load)
                valid_reg <= 1'b1;
            else if (m_tready)
                valid_reg <= 1'b0;
        end
    end

    // output character register
    always_ff @(posedge aclk) begin
        if (load) begin
            char_reg <= char_next;
            last_reg <= last_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = char_reg;
    assign m_tlast  = last_reg;

endmodule

// ----- design/tared_weight_hex_framer_unit.sv -----
`timescale 1ns / 1ps
// tared load-cell hex framer
// input channel s_*: one transfer per measurement, tdata holds the raw 24-bit
// converter word (bits 23:0) and the 16-bit temperature (bits 39:24)
// output channel m_*: one transfer per ascii character, tdata is the character,
// tlast marks the nineteenth and final character of each frame
// after reset the first 15 transfers are tare samples and give no output;
// the tare offset is then formed by a reciprocal multiply with s_tready low,
// and every later transfer yields one 19-character frame
// each accepted measurement is written into the queue, and the output
// character register loads from the queue head, one character per cycle
// while m_tready is high; a two-entry queue between the classifier and the
// serializer lets new measurements be taken while a frame is still going out
// when the receiver stalls, the output character holds, the queue fills and
// s_tready drops until an entry frees up
// reset is synchronous, active low, and clears the tare count, sum and offset
module tared_weight_hex_framer_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // adc_word [23:0], temperature [39:24]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // char_out [7:0]
    output logic        m_tlast
);

    logic                  q_push;
    logic                  q_ready;
    twhf_pkg::frame_rec_t  q_rec;
    logic                  q_pop;
    logic                  q_valid;
    twhf_pkg::frame_rec_t  q_head;

    twhf_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_ready  (q_ready),
        .q_push   (q_push),
        .q_rec    (q_rec)
    );

    twhf_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_rec   (q_rec),
        .push_ready (q_ready),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_rec   (q_head)
    );

    twhf_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (q_valid),
        .head_rec   (q_head),
        .pop        (q_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule

// ----- dv/tared_weight_hex_framer_unit_test.sv -----
`timescale 1ns / 1ps

module tared_weight_hex_framer_unit_test;

    localparam int          RANDOM_ITEMS = 290;
    localparam int          QUIET_TAIL   = 40;
    localparam int          HOLD_AT      = 120;
    localparam int          HOLD_CYCLES  = 400;
    localparam logic [7:0]  ASCII_A      = 8'h41;

    // one expected character transfer
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } char_xfer_t;

    // directed stimulus row, frame text left empty where the predictor decides
    typedef struct {
        logic [twhf_pkg::ADC_W-1:0]  adc;
        logic [twhf_pkg::TEMP_W-1:0] temp;
        string                       frame;
    } stim_row_t;

    logic              aclk     = 1'b0;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [39:0]       s_tdata  = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [7:0]        m_tdata;
    logic              m_tlast;

    // shadow of the tare state
    logic [twhf_pkg::CNT_W-1:0]  tare_cnt = '0;
    logic [twhf_pkg::SUM_W-1:0]  tare_acc = '0;
    logic [twhf_pkg::ADC_W-1:0]  tare_off = '0;

    char_xfer_t        pending_chars[$];
    stim_row_t         stim_table[$];
    int                mismatches  = 0;
    bit                hold_request = 1'b0;
    bit                hold_done    = 1'b0;
    bit                quiet_phase  = 1'b0;

    tared_weight_hex_framer_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // 20 ns clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // reset held low at the start, then released once
    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // run limit
    initial begin
        #10_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic logic [7:0] hex_ascii(input logic [3:0] nib);
        return (nib < 4'd10) ? (twhf_pkg::CH_ZERO + {4'b0000, nib})
                             : (ASCII_A + {4'b0000, nib} - 8'd10);
    endfunction

    // weigh one measurement: tare accumulation, or the 19-character frame text
    function automatic string weigh_frame(input logic [twhf_pkg::ADC_W-1:0] adc,
                                          input logic [twhf_pkg::TEMP_W-1:0] temp);
        logic [twhf_pkg::ADC_W-1:0] flipped;
        logic [31:0]      diff;
        logic [31:0]      mag;
        logic [7:0]       chk;
        logic [7:0]       tchk;
        logic             neg;
        string            s;
        flipped = adc ^ twhf_pkg::SIGN_FLIP;
        if (tare_cnt < twhf_pkg::TARE_SAMPLES) begin
            tare_acc = tare_acc + {4'b0000, flipped};
            tare_cnt = tare_cnt + 1'b1;
            if (tare_cnt == twhf_pkg::TARE_SAMPLES)
                tare_off = twhf_pkg::ADC_W'(tare_acc /
                                            twhf_pkg::SUM_W'(twhf_pkg::TARE_SAMPLES));
            return "";
        end
        diff = {8'h00, flipped} - {8'h00, tare_off};
        neg  = diff[31];
        mag  = neg ? (32'd0 - diff) : diff;
        chk  = diff[7:0] ^ diff[15:8] ^ diff[23:16] ^ diff[31:24];
        if (neg)
            chk = chk ^ 8'hFF;
        tchk = temp[15:8] ^ temp[7:0];
        s = "0000000000000000000";
        s[0] = neg ? twhf_pkg::CH_ONE : twhf_pkg::CH_ZERO;
        s[1] = twhf_pkg::CH_ZERO;
        s[2] = twhf_pkg::CH_X;
        for (int i = 0; i < 8; i++)
            s[10-i] = hex_ascii(mag[4*i +: 4]);
        s[11] = hex_ascii(chk[7:4]);
        s[12] = hex_ascii(chk[3:0]);
        for (int i = 0; i < 4; i++)
            s[16-i] = hex_ascii(temp[4*i +: 4]);
        s[17] = hex_ascii(tchk[7:4]);
        s[18] = hex_ascii(tchk[3:0]);
        return s;
    endfunction

    task automatic add_row(input logic [twhf_pkg::ADC_W-1:0] adc,
                           input logic [twhf_pkg::TEMP_W-1:0] temp,
                           input string frame);
        stim_row_t row;
        row.adc   = adc;
        row.temp  = temp;
        row.frame = frame;
        stim_table.push_back(row);
    endtask

    // offer one measurement, wait for its transfer, then queue its characters
    task automatic send_measurement(input logic [twhf_pkg::ADC_W-1:0] adc,
                                    input logic [twhf_pkg::TEMP_W-1:0] temp,
                                    input string typed);
        string      text;
        char_xfer_t c;
        if (!quiet_phase && $urandom_range(0, 2) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {temp, adc};
        do @(posedge aclk); while (!s_tready);
        text = weigh_frame(adc, temp);
        if (typed.len() != 0)
            text = typed;
        for (int i = 0; i < text.len(); i++) begin
            c.ch   = text[i];
            c.last = (i == twhf_pkg::FRAME_LEN - 1);
            pending_chars.push_back(c);
        end
    endtask

    // sender
    initial begin
        logic [twhf_pkg::ADC_W-1:0]  adc;
        logic [twhf_pkg::TEMP_W-1:0] temp;
        int                total;
        int                pick;
        int                delta;

        // tare words pair up around mid-scale so the offset lands on 0x800000
        for (int i = 0; i < 4; i++) begin
            add_row(24'h7FFFFF, 16'hFFFF, "");
            add_row(24'h800001, 16'h0000, "");
        end
        for (int i = 0; i < 3; i++) begin
            add_row(24'hFFFFFF, 16'h5A5A, "");
            add_row(24'h000001, 16'hA5A5, "");
        end
        add_row(24'h000000, 16'h8001, "");
        // zero difference, largest positive, most negative, minus one
        add_row(24'h000000, 16'h0000, "00x0000000000000000");
        add_row(24'h7FFFFF, 16'hFFFF, "00x007FFFFF7FFFFF00");
        add_row(24'h800000, 16'h1234, "10x0080000080123426");
        add_row(24'hFFFFFF, 16'hA5A5, "10x00000001FFA5A500");
        add_row(24'h000001, 16'h00FF, "");
        add_row(24'hC00000, 16'hFF00, "");
        add_row(24'h400000, 16'h8001, "");
        add_row(24'h3C96E1, 16'h7FFE, "");

        total = stim_table.size() + RANDOM_ITEMS;
        while (!aresetn) @(posedge aclk);
        repeat (3) @(posedge aclk);

        foreach (stim_table[i])
            send_measurement(stim_table[i].adc, stim_table[i].temp, stim_table[i].frame);

        // random measurements: mostly full-range, some close to the tare, some at the rails
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == HOLD_AT)
                hold_request = 1'b1;
            if (stim_table.size() + n >= total - QUIET_TAIL)
                quiet_phase = 1'b1;
            pick = $urandom_range(0, 9);
            if (pick < 6) begin
                adc = twhf_pkg::ADC_W'($urandom);
            end else if (pick < 8) begin
                delta = $urandom_range(0, 32) - 16;
                adc   = (tare_off + twhf_pkg::ADC_W'(delta)) ^ twhf_pkg::SIGN_FLIP;
            end else begin
                case ($urandom_range(0, 3))
                    0:       adc = 24'h000000;
                    1:       adc = 24'hFFFFFF;
                    2:       adc = 24'h7FFFFF;
                    default: adc = 24'h800000;
                endcase
            end
            case ($urandom_range(0, 7))
                0:       temp = 16'h0000;
                1:       temp = 16'hFFFF;
                default: temp = twhf_pkg::TEMP_W'($urandom);
            endcase
            send_measurement(adc, temp, "");
        end
        s_tvalid <= 1'b0;

        // drain, then let the block settle
        while (pending_chars.size() != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // receiver: random ready bursts, one long hold-off, no stalls at the tail
    initial begin
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_request && !hold_done) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_done = 1'b1;
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge aclk);
                if (!quiet_phase && $urandom_range(0, 1) == 0) begin
                    m_tready <= 1'b0;
                    repeat ($urandom_range(1, 11)) @(posedge aclk);
                end
            end
        end
    end

    // compare each character transfer with the oldest expected one
    always @(posedge aclk) begin : char_check
        char_xfer_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_chars.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transfer: char %h last %b", m_tdata, m_tlast);
            end else begin
                want = pending_chars.pop_front();
                if (m_tdata !== want.ch || m_tlast !== want.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: char exp %h got %h, last exp %b got %b",
                                 want.ch, m_tdata, want.last, m_tlast);
                end
            end
        end
    end

endmodule

// ----- files.f -----
+incdir+design
design/twhf_pkg.sv
design/twhf_front.sv
design/twhf_queue.sv
design/twhf_back.sv
design/tared_weight_hex_framer_unit.sv
dv/tared_weight_hex_framer_unit_test.sv
